FILE: rtl/step_pulse_timing_buffer_macros.svh
// assertion helpers shared by the rtl
// every use assumes a clock named clk and an active-low reset named rst_n
`ifndef STEP_PULSE_TIMING_BUFFER_MACROS_SVH
`define STEP_PULSE_TIMING_BUFFER_MACROS_SVH

// condition holds at every clock edge outside reset
`define SPT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spt_pkg.sv
`timescale 1ns / 1ps

package spt_pkg;

    // ring geometry, depth must be a power of two
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int LEVEL_W   = $clog2(DEPTH + 1);
    localparam int MIN_ITEMS = 3;
    localparam int SKEW      = 2;

    // field widths
    localparam int OP_W        = 2;
    localparam int OUT_FIELD_W = 12;
    localparam int OUT_BITS    = 12;
    localparam int STORE_W     = (OUT_BITS < OUT_FIELD_W) ? OUT_BITS : OUT_FIELD_W;
    localparam int RELOAD_W    = 32;
    localparam int TOTAL_W     = 38;
    localparam int FILL_W      = 7;
    localparam int ERR_W       = 3;

    // reset values
    localparam logic [RELOAD_W-1:0] PRIME_RELOAD   = RELOAD_W'(1000);
    localparam logic [TOTAL_W-1:0]  PRIME_TOTAL    = TOTAL_W'(MIN_ITEMS) * TOTAL_W'(PRIME_RELOAD);
    localparam logic [TOTAL_W-1:0]  MIN_TOTAL_INIT = TOTAL_W'(120000);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
    localparam logic [OP_W-1:0] OP_POP      = 2'd1;
    localparam logic [OP_W-1:0] OP_ERR_READ = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_POP_UNDER  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_PUSH_UNDER = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TOTAL      = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } spt_state_t;

    // access request from the control core to the ring store
    typedef struct packed {
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic                out_we;
        logic [ADDR_W-1:0]   out_waddr;
        logic [STORE_W-1:0]  out_wdata;
        logic                rl_we;
        logic [ADDR_W-1:0]   rl_waddr;
        logic [RELOAD_W-1:0] rl_wdata;
    } mem_req_t;

    // registered head entry returned by the ring store
    typedef struct packed {
        logic [STORE_W-1:0]  out_data;
        logic [RELOAD_W-1:0] reload_data;
    } mem_rsp_t;

endpackage

FILE: rtl/spt_if.sv
`timescale 1ns / 1ps

// step item channel
interface spt_in_if import spt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic [OUT_FIELD_W-1:0] push_out_bits;
    logic [RELOAD_W-1:0]    push_reload;

    modport source (output valid, output op, output push_out_bits, output push_reload,
                    input ready);
    modport sink (input valid, input op, input push_out_bits, input push_reload,
                  output ready);
endinterface

// result channel
interface spt_out_if import spt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   drive_valid;
    logic [OUT_FIELD_W-1:0] drive_out_bits;
    logic [RELOAD_W-1:0]    drive_reload;
    logic                   need_more;
    logic [FILL_W-1:0]      fill_level;
    logic [ERR_W-1:0]       error_code;

    modport source (output valid, output drive_valid, output drive_out_bits,
                    output drive_reload, output need_more, output fill_level,
                    output error_code, input ready);
    modport sink (input valid, input drive_valid, input drive_out_bits,
                  input drive_reload, input need_more, input fill_level,
                  input error_code, output ready);
endinterface

FILE: rtl/spt_ram.sv
`timescale 1ns / 1ps

module spt_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/spt_store.sv
`timescale 1ns / 1ps

module spt_store import spt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    logic [STORE_W-1:0]   out_rdata;
    logic [RELOAD_W-1:0]  rl_rdata;
    logic [MIN_ITEMS-1:0] out_prime_reg;
    logic [MIN_ITEMS-1:0] out_prime_next;
    logic [MIN_ITEMS-1:0] rl_prime_reg;
    logic [MIN_ITEMS-1:0] rl_prime_next;
    logic                 out_hit;
    logic                 rl_hit;
    logic                 out_hit_reg;
    logic                 rl_hit_reg;

    // step/dir word ring
    spt_ram #(
        .WIDTH (STORE_W),
        .WORDS (DEPTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (req.out_we),
        .waddr (req.out_waddr),
        .wdata (req.out_wdata),
        .re    (req.rd_en),
        .raddr (req.rd_addr),
        .rdata (out_rdata)
    );

    // timer reload ring
    spt_ram #(
        .WIDTH (RELOAD_W),
        .WORDS (DEPTH)
    ) u_rl_ram (
        .clk   (clk),
        .we    (req.rl_we),
        .waddr (req.rl_waddr),
        .wdata (req.rl_wdata),
        .re    (req.rd_en),
        .raddr (req.rd_addr),
        .rdata (rl_rdata)
    );

    // primed entries read as reset contents until first written
    always_comb
    begin
        out_prime_next = out_prime_reg;
        rl_prime_next  = rl_prime_reg;
        out_hit        = 1'b0;
        rl_hit         = 1'b0;
        for (int i = 0; i < MIN_ITEMS; i++)
        begin
            if (req.out_we && (req.out_waddr == ADDR_W'(i)))
            begin
                out_prime_next[i] = 1'b0;
            end
            if (req.rl_we && (req.rl_waddr == ADDR_W'(i)))
            begin
                rl_prime_next[i] = 1'b0;
            end
            if ((req.rd_addr == ADDR_W'(i)) && out_prime_reg[i])
            begin
                out_hit = 1'b1;
            end
            if ((req.rd_addr == ADDR_W'(i)) && rl_prime_reg[i])
            begin
                rl_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_prime_reg <= '1;
            rl_prime_reg  <= '1;
        end
        else
        begin
            out_prime_reg <= out_prime_next;
            rl_prime_reg  <= rl_prime_next;
        end
    end

    // prime hits follow the ram read latency
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            out_hit_reg <= out_hit;
            rl_hit_reg  <= rl_hit;
        end
    end

    assign rsp.out_data    = out_hit_reg ? '0 : out_rdata;
    assign rsp.reload_data = rl_hit_reg ? PRIME_RELOAD : rl_rdata;

endmodule

FILE: rtl/spt_core.sv
`timescale 1ns / 1ps
`include "step_pulse_timing_buffer_macros.svh"

module spt_core import spt_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TOTAL_W-1:0]  min_total,
    spt_in_if.sink              items,
    spt_out_if.source           results,
    output mem_req_t            mem_req,
    input  mem_rsp_t            mem_rsp
);

    spt_state_t          state_reg;
    spt_state_t          state_next;

    logic [OP_W-1:0]     op_reg;
    logic [STORE_W-1:0]  bits_reg;
    logic [RELOAD_W-1:0] reload_in_reg;

    logic [ADDR_W-1:0]   head_reg;
    logic [ADDR_W-1:0]   head_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  level_next;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic [ERR_W-1:0]    last_error_reg;
    logic [ERR_W-1:0]    last_error_next;

    logic                res_valid_reg;
    logic                drive_valid_reg;
    logic [STORE_W-1:0]  drive_bits_reg;
    logic [RELOAD_W-1:0] drive_reload_reg;
    logic                need_more_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [ERR_W-1:0]    error_reg;

    logic                in_fire;
    logic                commit;
    logic                full;
    logic                pop_ok;
    logic                push_ok;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W-1:0]  sum_sat;
    logic [TOTAL_W-1:0]  head_reload;
    logic [ADDR_W-1:0]   wr_base;
    logic [ADDR_W-1:0]   head_inc;
    logic                emit;
    logic [ERR_W-1:0]    err_report;
    logic                need_more;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!res_valid_reg || results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        items.ready = (state_reg == ST_IDLE);
        commit      = (state_reg == ST_EXEC) && (!res_valid_reg || results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_fire = items.valid && items.ready;

    // capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg        <= items.op;
            bits_reg      <= items.push_out_bits[STORE_W-1:0];
            reload_in_reg <= items.push_reload;
        end
    end

    // head read is issued at accept, data is back in the exec cycle
    assign full        = (level_reg == LEVEL_W'(DEPTH));
    assign pop_ok      = (level_reg >= LEVEL_W'(MIN_ITEMS));
    assign push_ok     = !full && (level_reg > LEVEL_W'(SKEW));
    assign sum         = {1'b0, total_reg} + (TOTAL_W + 1)'(reload_in_reg);
    assign sum_sat     = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    assign head_reload = TOTAL_W'(mem_rsp.reload_data);
    assign wr_base     = head_reg + level_reg[ADDR_W-1:0];
    assign head_inc    = head_reg + ADDR_W'(1);

    // operation effect on the ring state
    always_comb
    begin
        head_next       = head_reg;
        level_next      = level_reg;
        total_next      = total_reg;
        last_error_next = last_error_reg;
        emit            = 1'b0;
        err_report      = last_error_reg;
        unique case (op_reg)
            OP_PUSH:
            begin
                if (full)
                begin
                    last_error_next = ERR_OVERFLOW;
                end
                else
                begin
                    total_next = sum_sat;
                    if (push_ok)
                    begin
                        level_next = level_reg + LEVEL_W'(1);
                    end
                    else
                    begin
                        last_error_next = ERR_PUSH_UNDER;
                    end
                end
                err_report = last_error_next;
            end
            OP_POP:
            begin
                if (pop_ok)
                begin
                    emit = 1'b1;
                    if (total_reg > head_reload)
                    begin
                        total_next = total_reg - head_reload;
                    end
                    else
                    begin
                        last_error_next = ERR_TOTAL;
                    end
                    head_next  = head_inc;
                    level_next = level_reg - LEVEL_W'(1);
                end
                else
                begin
                    last_error_next = ERR_POP_UNDER;
                end
                err_report = last_error_next;
            end
            OP_ERR_READ:
            begin
                last_error_next = ERR_NONE;
            end
            default:
            begin
                err_report = last_error_reg;
            end
        endcase
    end

    assign need_more = (level_next < LEVEL_W'(MIN_ITEMS))
                     || ((total_next < min_total) && (level_next != LEVEL_W'(DEPTH)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            level_reg      <= LEVEL_W'(MIN_ITEMS);
            total_reg      <= PRIME_TOTAL;
            last_error_reg <= ERR_NONE;
        end
        else if (commit)
        begin
            head_reg       <= head_next;
            level_reg      <= level_next;
            total_reg      <= total_next;
            last_error_reg <= last_error_next;
        end
    end

    // ring access: reload lands two slots behind the step bits
    always_comb
    begin
        mem_req.rd_en     = in_fire;
        mem_req.rd_addr   = head_reg;
        mem_req.out_we    = commit && (op_reg == OP_PUSH) && push_ok;
        mem_req.out_waddr = wr_base;
        mem_req.out_wdata = bits_reg;
        mem_req.rl_we     = commit && (op_reg == OP_PUSH) && push_ok;
        mem_req.rl_waddr  = wr_base - ADDR_W'(SKEW);
        mem_req.rl_wdata  = reload_in_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            drive_valid_reg  <= emit;
            drive_bits_reg   <= emit ? mem_rsp.out_data : '0;
            drive_reload_reg <= emit ? mem_rsp.reload_data : '0;
            need_more_reg    <= need_more;
            fill_reg         <= FILL_W'(level_next);
            error_reg        <= err_report;
        end
    end

    assign results.valid          = res_valid_reg;
    assign results.drive_valid    = drive_valid_reg;
    assign results.drive_out_bits = OUT_FIELD_W'(drive_bits_reg);
    assign results.drive_reload   = drive_reload_reg;
    assign results.need_more      = need_more_reg;
    assign results.fill_level     = fill_reg;
    assign results.error_code     = error_reg;

    // checks
    `SPT_ASSERT_ALWAYS(a_level_bound, level_reg <= LEVEL_W'(DEPTH), "fill level above depth")
    `SPT_ASSERT_NEXT(a_pop_advance, commit && (op_reg == OP_POP) && pop_ok,
        head_reg == $past(head_inc), "pop did not advance head by one")
    `SPT_ASSERT_NEXT(a_push_total, commit && (op_reg == OP_PUSH),
        total_reg >= $past(total_reg), "push decreased buffered time")
    `SPT_ASSERT_NEXT(a_err_clear, commit && (op_reg == OP_ERR_READ),
        last_error_reg == ERR_NONE, "error read did not clear sticky error")

endmodule

FILE: rtl/step_pulse_timing_buffer.sv
`timescale 1ns / 1ps

// Step pulse timing buffer: a ring of step/dir words and timer reloads that
// feeds a stepper pulse generator.
// items channel: op 0 pushes push_out_bits/push_reload, op 1 is a timer
// expiry pop, op 2 reads and clears the sticky error. Every transaction gives
// exactly one transaction on the results channel with the popped pair (when
// drive_valid is set), need_more, fill_level and error_code.
// cfg_we/cfg_data write min_total_time, the buffered-time threshold below
// which need_more is raised; write only while the block is idle.
// Timing: an item is accepted in the idle cycle, the head entry is read from
// the ring rams in that cycle and the update is applied in the exec state once
// the output register is free, which loads the result register as well. The
// block takes no new item until that update is done.
// The result sits in an output register; the next item is accepted while it
// waits, but that item's update holds until the receiver takes the result.
// Reset (rst_n low, asynchronous) primes three entries with zero step bits
// and the default reload, clears the error and sets the threshold to 120000;
// no clearing pass runs, the block is ready in the first cycle after reset.
module step_pulse_timing_buffer import spt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    spt_in_if.sink             items,
    spt_out_if.source          results,
    input  logic               cfg_we,
    input  logic [TOTAL_W-1:0] cfg_data
);

    logic [TOTAL_W-1:0] min_total_reg;
    mem_req_t           mem_req;
    mem_rsp_t           mem_rsp;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_total_reg <= MIN_TOTAL_INIT;
        end
        else if (cfg_we)
        begin
            min_total_reg <= cfg_data;
        end
    end

    spt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .min_total (min_total_reg),
        .items     (items),
        .results   (results),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp)
    );

    spt_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

endmodule
